// ----- sv/usfsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usfsm_pkg
// Shared codes, word types and flag decode for the flash session FSM.
// ----------------------------------------------------------------------------
package usfsm_pkg;

    // Session / programming states
    localparam logic [2:0] ST_DEFAULT     = 3'd0;
    localparam logic [2:0] ST_EXTENDED    = 3'd1;
    localparam logic [2:0] ST_PROG        = 3'd2;
    localparam logic [2:0] ST_SECURED     = 3'd3;
    localparam logic [2:0] ST_ERASED      = 3'd4;
    localparam logic [2:0] ST_DOWNLOADING = 3'd5;
    localparam logic [2:0] ST_PROGRAMMED  = 3'd6;
    localparam logic [2:0] ST_CHECKED     = 3'd7;

    // Event codes
    localparam logic [3:0] CMD_SESSION  = 4'd0;
    localparam logic [3:0] CMD_UNLOCK   = 4'd1;
    localparam logic [3:0] CMD_LOCK     = 4'd2;
    localparam logic [3:0] CMD_ERASE_OK = 4'd3;
    localparam logic [3:0] CMD_DL_START = 4'd4;
    localparam logic [3:0] CMD_DL_ABORT = 4'd5;
    localparam logic [3:0] CMD_EXIT_OK  = 4'd6;
    localparam logic [3:0] CMD_CHECK_OK = 4'd7;
    localparam logic [3:0] CMD_QUERY    = 4'd8;

    // Security levels
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_L1   = 2'd1;
    localparam logic [1:0] LVL_L3   = 2'd2;

    // UDS session bytes
    localparam logic [7:0] SESS_PROGRAMMING = 8'h02;
    localparam logic [7:0] SESS_EXTENDED    = 8'h03;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] session_code;
        logic [1:0] sec_level;
    } item_t;

    typedef struct packed {
        logic [2:0] fsm_state;
        logic       accepted;
        logic       level_open;
        logic       security_unlocked;
        logic       may_access_security;
        logic       may_erase;
        logic       may_download;
        logic       may_transfer;
        logic       may_check;
    } result_t;

    function automatic logic is_unlocked(input logic [2:0] s);
        is_unlocked = (s >= ST_SECURED);
    endfunction

endpackage
`default_nettype wire

// ----- sv/usfsm_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usfsm_in_stage
// Input register: captures one event word and holds it until the core
// moves it into the result register.
// ----------------------------------------------------------------------------
module usfsm_in_stage
    import usfsm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  item_t item,
    input  wire         advance,
    output logic        item_valid,
    output item_t       item_q
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item;
        end
    end

    assign item_valid = valid_reg;
    assign item_q     = item_reg;

endmodule
`default_nettype wire

// ----- sv/usfsm_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usfsm_core
// Session/security state registers and the event update. Produces the
// result word of the event being retired this cycle.
// ----------------------------------------------------------------------------
module usfsm_core
    import usfsm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    input  wire  [1:0]  flash_unlock_level,
    input  wire         advance,
    input  wire  item_t item_q,
    output result_t     result
);

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [1:0] ext_unlock_reg;
    logic [1:0] ext_unlock_next;
    logic [1:0] prog_unlock_reg;
    logic [1:0] prog_unlock_next;
    logic [1:0] fl_level_reg;
    logic       ok;
    logic       fl_valid;
    logic [1:0] cur_level;

    // only L1/L3 can secure the programming session
    assign fl_valid = (fl_level_reg == LVL_L1) || (fl_level_reg == LVL_L3);

    always_comb
    begin
        mode_next        = mode_reg;
        ext_unlock_next  = ext_unlock_reg;
        prog_unlock_next = prog_unlock_reg;
        ok               = 1'b1;
        case (item_q.cmd)
            CMD_SESSION:
            begin
                if (item_q.session_code == SESS_EXTENDED)
                begin
                    mode_next = ST_EXTENDED;
                end
                else if (item_q.session_code == SESS_PROGRAMMING)
                begin
                    mode_next = (fl_valid && prog_unlock_reg == fl_level_reg) ?
                                ST_SECURED : ST_PROG;
                end
                else
                begin
                    // default or unknown session drops both unlocks
                    ext_unlock_next  = LVL_NONE;
                    prog_unlock_next = LVL_NONE;
                    mode_next        = ST_DEFAULT;
                end
            end
            CMD_UNLOCK:
            begin
                if (item_q.sec_level inside {LVL_L1, LVL_L3})
                begin
                    if (mode_reg == ST_EXTENDED)
                    begin
                        ext_unlock_next = item_q.sec_level;
                    end
                    else
                    begin
                        prog_unlock_next = item_q.sec_level;
                        if (mode_reg == ST_PROG && fl_valid &&
                            item_q.sec_level == fl_level_reg)
                        begin
                            mode_next = ST_SECURED;
                        end
                    end
                end
            end
            CMD_LOCK:
            begin
                if (mode_reg == ST_EXTENDED)
                begin
                    ext_unlock_next = LVL_NONE;
                end
                else
                begin
                    prog_unlock_next = LVL_NONE;
                    if (is_unlocked(mode_reg))
                    begin
                        mode_next = ST_PROG;
                    end
                end
            end
            CMD_ERASE_OK:
            begin
                if (mode_reg inside {ST_SECURED, ST_ERASED, ST_PROGRAMMED, ST_CHECKED})
                begin
                    mode_next = ST_ERASED;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            CMD_DL_START:
            begin
                if (mode_reg == ST_ERASED)
                begin
                    mode_next = ST_DOWNLOADING;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            CMD_DL_ABORT:
            begin
                if (mode_reg inside {ST_DOWNLOADING, ST_ERASED})
                begin
                    mode_next = ST_SECURED;
                end
            end
            CMD_EXIT_OK:
            begin
                if (mode_reg == ST_DOWNLOADING)
                begin
                    mode_next = ST_PROGRAMMED;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            CMD_CHECK_OK:
            begin
                if (mode_reg == ST_PROGRAMMED)
                begin
                    mode_next = ST_CHECKED;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            CMD_QUERY:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign cur_level = (mode_next == ST_EXTENDED) ? ext_unlock_next : prog_unlock_next;

    always_comb
    begin
        result.fsm_state           = mode_next;
        result.accepted            = ok;
        result.level_open          = (item_q.sec_level == LVL_NONE) ||
                                     (mode_next != ST_DEFAULT &&
                                      cur_level == item_q.sec_level);
        result.security_unlocked   = is_unlocked(mode_next);
        result.may_access_security = (mode_next == ST_PROG) || (mode_next == ST_EXTENDED) ||
                                     is_unlocked(mode_next);
        result.may_erase           = mode_next inside {ST_SECURED, ST_ERASED,
                                                       ST_PROGRAMMED, ST_CHECKED};
        result.may_download        = (mode_next == ST_ERASED);
        result.may_transfer        = (mode_next == ST_DOWNLOADING);
        result.may_check           = (mode_next == ST_PROGRAMMED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ST_DEFAULT;
            ext_unlock_reg  <= LVL_NONE;
            prog_unlock_reg <= LVL_NONE;
            fl_level_reg    <= LVL_L1;
        end
        else
        begin
            if (advance)
            begin
                mode_reg        <= mode_next;
                ext_unlock_reg  <= ext_unlock_next;
                prog_unlock_reg <= prog_unlock_next;
            end
            if (cfg_valid)
            begin
                fl_level_reg <= flash_unlock_level;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/usfsm_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usfsm_out_stage
// Result register: holds one result word until the consumer takes it and
// tells the input side when the next event may retire.
// ----------------------------------------------------------------------------
module usfsm_out_stage
    import usfsm_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           item_valid,
    input  wire  result_t result,
    output logic          advance,
    output logic          out_valid,
    input  wire           out_ready,
    output result_t       result_q
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // retire when the slot is empty or being drained this cycle
    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign result_q  = result_reg;

endmodule
`default_nettype wire

// ----- sv/uds_flash_session_security_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uds_flash_session_security_fsm
// UDS flash-programming session and security state machine, one event word
// in, one result word out.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | cmd, session_code, sec_level
//  out     | out_valid / out_ready| fsm_state, accepted, level_open, flags
//  cfg     | cfg_valid / cfg_ready| flash_unlock_level
//
//  One event per cycle sustained while the output is not stalled. The input
//  register feeds the state update, whose result word is captured in the
//  result register.
//  Reset: default state, no unlocks, flash_unlock_level = L1.
//  A stalled output holds its word; the input register still takes one more
//  word, then in_ready drops until the output drains. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module uds_flash_session_security_fsm
    import usfsm_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [3:0] cmd,
    input  wire  [7:0] session_code,
    input  wire  [1:0] sec_level,

    output logic       out_valid,
    input  wire        out_ready,
    output logic [2:0] fsm_state,
    output logic       accepted,
    output logic       level_open,
    output logic       security_unlocked,
    output logic       may_access_security,
    output logic       may_erase,
    output logic       may_download,
    output logic       may_transfer,
    output logic       may_check,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] flash_unlock_level
);

    item_t   item;
    item_t   item_q;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t result_q;

    assign item.cmd          = cmd;
    assign item.session_code = session_code;
    assign item.sec_level    = sec_level;
    assign cfg_ready         = 1'b1;

    usfsm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (item),
        .advance    (advance),
        .item_valid (item_valid),
        .item_q     (item_q)
    );

    usfsm_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .flash_unlock_level (flash_unlock_level),
        .advance            (advance),
        .item_q             (item_q),
        .result             (result)
    );

    usfsm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_q   (result_q)
    );

    assign fsm_state           = result_q.fsm_state;
    assign accepted            = result_q.accepted;
    assign level_open          = result_q.level_open;
    assign security_unlocked   = result_q.security_unlocked;
    assign may_access_security = result_q.may_access_security;
    assign may_erase           = result_q.may_erase;
    assign may_download        = result_q.may_download;
    assign may_transfer        = result_q.may_transfer;
    assign may_check           = result_q.may_check;

endmodule
`default_nettype wire

// ----- verif/tb_uds_flash_session_security_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uds_flash_session_security_fsm
// Self-checking bench for the flash session/security FSM. Event words are
// tracked by a scoreboard that keeps its own session state and predicts
// each status word. The run starts with directed event sequences, then moves
// through random programming flows, extended-session flows and noise words under several unlock-level settings and
// idle/stall mixes. It includes one long output hold-off to back up the pipe.
// ----------------------------------------------------------------------------
module tb_uds_flash_session_security_fsm;
    import usfsm_pkg::*;

    localparam int        CYCLE_LIMIT     = 200000;
    localparam int        PRESSURE_AT     = 60;
    localparam int        HOLD_CYCLES     = 250;
    localparam logic [3:0] CMD_UNDEF_LO   = 4'd9;
    localparam logic [3:0] CMD_UNDEF_HI   = 4'd15;
    localparam logic [1:0] LVL_OTHER      = 2'd3;
    localparam logic [7:0] SESS_DEFAULT   = 8'h01;

    // ------------------------------------------------------------------------
    // Scoreboard: session state copy plus queue of predicted status words
    // ------------------------------------------------------------------------
    class session_scoreboard;
        logic [2:0] mode;
        logic [1:0] ext_level;
        logic [1:0] prog_level;
        logic [1:0] unlock_cfg;
        result_t    pending_status[$];
        int         n_checked;
        int         n_errors;
        int         n_reported;

        function new();
            mode       = ST_DEFAULT;
            ext_level  = LVL_NONE;
            prog_level = LVL_NONE;
            unlock_cfg = LVL_L1;
            n_checked  = 0;
            n_errors   = 0;
            n_reported = 0;
        endfunction

        function void set_level(logic [1:0] v);
            unlock_cfg = v;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        function logic opens_prog(logic [1:0] lvl);
            return (unlock_cfg == LVL_L1 || unlock_cfg == LVL_L3) && lvl == unlock_cfg;
        endfunction

        function result_t predict_status(item_t w);
            result_t    r;
            logic       ok;
            logic [1:0] cur;
            ok = 1'b1;
            case (w.cmd)
                CMD_SESSION:
                begin
                    if (w.session_code == SESS_EXTENDED)
                        mode = ST_EXTENDED;
                    else if (w.session_code == SESS_PROGRAMMING)
                        mode = opens_prog(prog_level) ? ST_SECURED : ST_PROG;
                    else
                    begin
                        // any other byte falls back to default and drops unlocks
                        ext_level  = LVL_NONE;
                        prog_level = LVL_NONE;
                        mode       = ST_DEFAULT;
                    end
                end
                CMD_UNLOCK:
                begin
                    if (w.sec_level == LVL_L1 || w.sec_level == LVL_L3)
                    begin
                        if (mode == ST_EXTENDED)
                            ext_level = w.sec_level;
                        else
                        begin
                            prog_level = w.sec_level;
                            if (mode == ST_PROG && opens_prog(w.sec_level))
                                mode = ST_SECURED;
                        end
                    end
                end
                CMD_LOCK:
                begin
                    if (mode == ST_EXTENDED)
                        ext_level = LVL_NONE;
                    else
                    begin
                        prog_level = LVL_NONE;
                        if (mode >= ST_SECURED)
                            mode = ST_PROG;
                    end
                end
                CMD_ERASE_OK:
                begin
                    if (mode == ST_SECURED || mode == ST_ERASED ||
                        mode == ST_PROGRAMMED || mode == ST_CHECKED)
                        mode = ST_ERASED;
                    else
                        ok = 1'b0;
                end
                CMD_DL_START:
                begin
                    if (mode == ST_ERASED)
                        mode = ST_DOWNLOADING;
                    else
                        ok = 1'b0;
                end
                CMD_DL_ABORT:
                begin
                    if (mode == ST_DOWNLOADING || mode == ST_ERASED)
                        mode = ST_SECURED;
                end
                CMD_EXIT_OK:
                begin
                    if (mode == ST_DOWNLOADING)
                        mode = ST_PROGRAMMED;
                    else
                        ok = 1'b0;
                end
                CMD_CHECK_OK:
                begin
                    if (mode == ST_PROGRAMMED)
                        mode = ST_CHECKED;
                    else
                        ok = 1'b0;
                end
                CMD_QUERY:
                    ;
                default:
                    ok = 1'b0;
            endcase

            cur = (mode == ST_EXTENDED) ? ext_level : prog_level;
            r.fsm_state           = mode;
            r.accepted            = ok;
            r.level_open          = (w.sec_level == LVL_NONE) ||
                                    (mode != ST_DEFAULT && cur == w.sec_level);
            r.security_unlocked   = (mode >= ST_SECURED);
            r.may_access_security = (mode != ST_DEFAULT);
            r.may_erase           = (mode == ST_SECURED || mode == ST_ERASED ||
                                     mode == ST_PROGRAMMED || mode == ST_CHECKED);
            r.may_download        = (mode == ST_ERASED);
            r.may_transfer        = (mode == ST_DOWNLOADING);
            r.may_check           = (mode == ST_PROGRAMMED);
            return r;
        endfunction

        function void note_event(item_t w);
            pending_status.push_back(predict_status(w));
        endfunction

        function void check_result(result_t got);
            result_t want;
            string   diff;
            if (pending_status.size() == 0)
            begin
                n_errors++;
                if (n_reported < 10)
                    $display("unexpected status word: %p", got);
                n_reported++;
                return;
            end
            want = pending_status.pop_front();
            diff = "";
            if (got.fsm_state !== want.fsm_state)
                diff = {diff, $sformatf(" fsm_state %0d/%0d", want.fsm_state, got.fsm_state)};
            if (got.accepted !== want.accepted)
                diff = {diff, $sformatf(" accepted %b/%b", want.accepted, got.accepted)};
            if (got.level_open !== want.level_open)
                diff = {diff, $sformatf(" level_open %b/%b", want.level_open, got.level_open)};
            if (got.security_unlocked !== want.security_unlocked)
                diff = {diff, $sformatf(" security_unlocked %b/%b",
                                        want.security_unlocked, got.security_unlocked)};
            if (got.may_access_security !== want.may_access_security)
                diff = {diff, $sformatf(" may_access_security %b/%b",
                                        want.may_access_security, got.may_access_security)};
            if (got.may_erase !== want.may_erase)
                diff = {diff, $sformatf(" may_erase %b/%b", want.may_erase, got.may_erase)};
            if (got.may_download !== want.may_download)
                diff = {diff, $sformatf(" may_download %b/%b",
                                        want.may_download, got.may_download)};
            if (got.may_transfer !== want.may_transfer)
                diff = {diff, $sformatf(" may_transfer %b/%b",
                                        want.may_transfer, got.may_transfer)};
            if (got.may_check !== want.may_check)
                diff = {diff, $sformatf(" may_check %b/%b", want.may_check, got.may_check)};
            if (diff != "")
            begin
                n_errors++;
                if (n_reported < 10)
                    $display("status word %0d mismatch (expected/actual):%s", n_checked, diff);
                n_reported++;
            end
            n_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic       clk                = 1'b0;
    logic       rst_n              = 1'b0;
    logic       in_valid           = 1'b0;
    logic       in_ready;
    logic [3:0] cmd                = '0;
    logic [7:0] session_code       = '0;
    logic [1:0] sec_level          = '0;
    logic       out_valid;
    logic       out_ready          = 1'b0;
    logic [2:0] fsm_state;
    logic       accepted;
    logic       level_open;
    logic       security_unlocked;
    logic       may_access_security;
    logic       may_erase;
    logic       may_download;
    logic       may_transfer;
    logic       may_check;
    logic       cfg_valid          = 1'b0;
    logic       cfg_ready;
    logic [1:0] flash_unlock_level = '0;

    session_scoreboard board;
    result_t           observed;
    int                words_sent      = 0;
    int                sender_idle_pct = 0;
    int                sink_stall_pct  = 0;
    int                hold_left       = 0;
    logic              pressure_done   = 1'b0;
    int                cycle_count     = 0;

    uds_flash_session_security_fsm u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .cmd                 (cmd),
        .session_code        (session_code),
        .sec_level           (sec_level),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .fsm_state           (fsm_state),
        .accepted            (accepted),
        .level_open          (level_open),
        .security_unlocked   (security_unlocked),
        .may_access_security (may_access_security),
        .may_erase           (may_erase),
        .may_download        (may_download),
        .may_transfer        (may_transfer),
        .may_check           (may_check),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .flash_unlock_level  (flash_unlock_level)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: check accepted words, random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            observed = {fsm_state, accepted, level_open, security_unlocked,
                        may_access_security, may_erase, may_download,
                        may_transfer, may_check};
            board.check_result(observed);
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!pressure_done && board.n_checked >= PRESSURE_AT)
        begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic item_t ev(logic [3:0] c, logic [7:0] s, logic [1:0] l);
        item_t w;
        w.cmd          = c;
        w.session_code = s;
        w.sec_level    = l;
        return w;
    endfunction

    function automatic item_t noise_item();
        item_t w;
        w.cmd          = ($urandom_range(99) < 80) ? 4'($urandom_range(8))
                                                    : 4'($urandom_range(15));
        w.session_code = 8'($urandom_range(255));
        w.sec_level    = 2'($urandom_range(3));
        if (w.cmd == CMD_SESSION && $urandom_range(1) == 0)
            w.session_code = 8'($urandom_range(1, 3));
        return w;
    endfunction

    // called at a rising edge; returns at the edge the word is taken
    task automatic send_word(item_t w);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= w.cmd;
        session_code <= w.session_code;
        sec_level    <= w.sec_level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_event(w);
        words_sent++;
    endtask

    task automatic write_unlock_level(logic [1:0] v);
        cfg_valid          <= 1'b1;
        flash_unlock_level <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_level(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // session 2 and unlock in either order, erase, then download loops ending in check or abort, each followed by erase
    task automatic run_prog_flow();
        item_t      steps[$];
        logic [1:0] code;
        item_t      sess;
        item_t      unl;
        code = ($urandom_range(99) < 80) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
        sess = ev(CMD_SESSION, SESS_PROGRAMMING, 2'($urandom_range(3)));
        unl  = ev(CMD_UNLOCK, 8'($urandom_range(255)), code);
        if ($urandom_range(99) < 30)
        begin
            // unlock ahead of session entry, so entry can go straight to secured
            steps.push_back(unl);
            steps.push_back(sess);
        end
        else
        begin
            steps.push_back(sess);
            steps.push_back(unl);
        end
        steps.push_back(ev(CMD_ERASE_OK, 8'($urandom_range(255)), 2'($urandom_range(3))));
        repeat ($urandom_range(1, 3))
        begin
            steps.push_back(ev(CMD_DL_START, 8'($urandom_range(255)), 2'($urandom_range(3))));
            if ($urandom_range(3) == 0)
                steps.push_back(ev(CMD_DL_ABORT, 8'($urandom_range(255)),
                                   2'($urandom_range(3))));
            else
            begin
                steps.push_back(ev(CMD_EXIT_OK, 8'($urandom_range(255)),
                                   2'($urandom_range(3))));
                steps.push_back(ev(CMD_CHECK_OK, 8'($urandom_range(255)),
                                   2'($urandom_range(3))));
            end
            steps.push_back(ev(CMD_ERASE_OK, 8'($urandom_range(255)), 2'($urandom_range(3))));
        end
        case ($urandom_range(3))
            0: steps.push_back(ev(CMD_LOCK, 8'($urandom_range(255)), 2'($urandom_range(3))));
            1: steps.push_back(ev(CMD_QUERY, 8'($urandom_range(255)), 2'($urandom_range(3))));
            2: steps.push_back(ev(CMD_SESSION, 8'($urandom_range(255)), 2'($urandom_range(3))));
            default: steps.push_back(ev(CMD_SESSION, SESS_DEFAULT, 2'($urandom_range(3))));
        endcase
        foreach (steps[i])
        begin
            if ($urandom_range(9) == 0)
                send_word(noise_item());
            send_word(steps[i]);
        end
    endtask

    task automatic run_ext_flow();
        send_word(ev(CMD_SESSION, SESS_EXTENDED, 2'($urandom_range(3))));
        send_word(ev(CMD_UNLOCK, 8'($urandom_range(255)), 2'($urandom_range(3))));
        send_word(ev(CMD_QUERY, 8'($urandom_range(255)), 2'($urandom_range(3))));
        if ($urandom_range(1) == 0)
            send_word(ev(CMD_LOCK, 8'($urandom_range(255)), 2'($urandom_range(3))));
        send_word(ev(CMD_QUERY, 8'($urandom_range(255)), 2'($urandom_range(3))));
        if ($urandom_range(1) == 0)
            send_word(ev(CMD_SESSION, SESS_PROGRAMMING, 2'($urandom_range(3))));
    endtask

    task automatic run_phase(logic [1:0] lvl, int idle_pct, int stall_pct, int target);
        int r;
        write_unlock_level(lvl);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        while (words_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 55)
                run_prog_flow();
            else if (r < 70)
                run_ext_flow();
            else
                send_word(noise_item());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_unlock_level(LVL_L1);

        send_word(ev(CMD_QUERY, 8'h00, LVL_NONE));
        send_word(ev(CMD_QUERY, 8'hFF, LVL_L1));
        send_word(ev(CMD_SESSION, SESS_EXTENDED, LVL_L3));
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_L3));
        send_word(ev(CMD_QUERY, 8'h00, LVL_L3));
        send_word(ev(CMD_LOCK, 8'h00, LVL_L3));
        send_word(ev(CMD_SESSION, SESS_PROGRAMMING, LVL_NONE));
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_NONE));
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_OTHER));
        send_word(ev(CMD_ERASE_OK, 8'h00, LVL_NONE));
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_L1));
        send_word(ev(CMD_ERASE_OK, 8'h00, LVL_L1));
        send_word(ev(CMD_DL_START, 8'h00, LVL_L1));
        send_word(ev(CMD_EXIT_OK, 8'h00, LVL_L1));
        send_word(ev(CMD_CHECK_OK, 8'h00, LVL_L1));
        send_word(ev(CMD_DL_START, 8'h00, LVL_L1));
        send_word(ev(CMD_ERASE_OK, 8'h00, LVL_L1));
        send_word(ev(CMD_DL_ABORT, 8'h00, LVL_L1));
        send_word(ev(CMD_LOCK, 8'h00, LVL_L1));
        send_word(ev(CMD_QUERY, 8'h00, LVL_OTHER));
        send_word(ev(CMD_UNDEF_HI, 8'hFF, LVL_OTHER));
        send_word(ev(CMD_UNDEF_LO, 8'h00, LVL_L1));
        send_word(ev(CMD_SESSION, 8'hFF, LVL_L1));
        send_word(ev(CMD_SESSION, SESS_DEFAULT, LVL_NONE));
        send_word(ev(CMD_SESSION, 8'h00, LVL_NONE));
        settle();

        // out-of-range unlock level: programming session never secures
        write_unlock_level(LVL_OTHER);
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_L3));
        send_word(ev(CMD_SESSION, SESS_PROGRAMMING, LVL_L3));
        send_word(ev(CMD_UNLOCK, 8'h00, LVL_L1));
        settle();

        run_phase(LVL_L1, 0, 0, 260);
        run_phase(LVL_L3, 53, 0, 490);
        run_phase(LVL_NONE, 0, 53, 720);
        run_phase(LVL_OTHER, 6, 6, 950);

        sink_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (board.n_errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
